>>> sv/fpd_pkg.sv
// Shared types, constants and helpers for the flight phase detector.
package fpd_pkg;

    // Sample window geometry; the depth must be a power of two from 4 to 16.
    localparam int WINDOW_DEPTH = 4;
    localparam int DEPTH_LOG2   = $clog2(WINDOW_DEPTH);

    // Field widths.
    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = SAMPLE_W + DEPTH_LOG2;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int THR_W    = 17;
    localparam int FRAC_W   = 9;
    localparam int FRAC_SH  = 8;
    localparam int PROD_W   = SAMPLE_W + FRAC_W + 1;
    localparam int PHASE_W  = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDED   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 2'd3;

    localparam logic [THR_W-1:0]  RST_LAUNCH   = 17'd500;
    localparam logic [THR_W-1:0]  RST_STABLE   = 17'd500;
    localparam logic [THR_W-1:0]  RST_LANDED   = 17'd500;
    localparam logic [FRAC_W-1:0] RST_FRACTION = 9'd192;

    // Flight phase codes.
    localparam logic [PHASE_W-1:0] PH_PAD     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ASCENT  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_APOGEE  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DESCENT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    // Decoupling queue depth (power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register set.
    typedef struct packed {
        logic [THR_W-1:0]  launch_threshold;
        logic [THR_W-1:0]  stable_delta;
        logic [THR_W-1:0]  landed_threshold;
        logic [FRAC_W-1:0] release_fraction;
    } t_cfg;

    // One classified sample as handed from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] newest;
        logic                       launch;
        logic                       stable;
        logic                       falling;
        logic                       landed;
    } t_item;

    // Magnitude of the difference of two samples.
    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                   input logic signed [SAMPLE_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

>>> sv/fpd_front.sv
// Front end: sample window, running sum, average and per-sample condition flags.
module fpd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpd_pkg::t_cfg                       i_cfg,
    input  logic                                i_in_valid,
    input  logic signed [fpd_pkg::SAMPLE_W-1:0] i_altitude_sample,
    input  logic                                i_full,
    output logic                                o_push,
    output fpd_pkg::t_item                      o_item
);

    logic signed [fpd_pkg::SAMPLE_W-1:0] r_win [fpd_pkg::WINDOW_DEPTH];
    logic signed [fpd_pkg::SUM_W-1:0]    r_sum;
    logic signed [fpd_pkg::SUM_W-1:0]    n_sum;
    logic signed [fpd_pkg::SUM_W-1:0]    shifted;
    logic signed [fpd_pkg::SAMPLE_W-1:0] mean;
    logic signed [fpd_pkg::DIFF_W-1:0]   mean_x;
    logic signed [fpd_pkg::DIFF_W-1:0]   launch_x;
    logic signed [fpd_pkg::DIFF_W-1:0]   landed_x;
    logic [fpd_pkg::DIFF_W-1:0]          delta_x;
    logic signed [fpd_pkg::SAMPLE_W-1:0] tap_a, tap_b, tap_c, tap_d;

    // A sample is taken whenever the queue has room.
    assign o_push = i_in_valid && !i_full;

    // The oldest sample leaves the running sum as the new one enters.
    assign n_sum   = r_sum - fpd_pkg::SUM_W'(r_win[fpd_pkg::WINDOW_DEPTH-1])
                   + fpd_pkg::SUM_W'(i_altitude_sample);
    assign shifted = n_sum >>> fpd_pkg::DEPTH_LOG2;
    assign mean    = shifted[fpd_pkg::SAMPLE_W-1:0];

    // The four newest samples, with the incoming one first.
    assign tap_a = i_altitude_sample;
    assign tap_b = r_win[0];
    assign tap_c = r_win[1];
    assign tap_d = r_win[2];

    // Threshold compares are done signed at one bit above the sample width.
    assign mean_x   = fpd_pkg::DIFF_W'(mean);
    assign launch_x = $signed(fpd_pkg::DIFF_W'(i_cfg.launch_threshold));
    assign landed_x = $signed(fpd_pkg::DIFF_W'(i_cfg.landed_threshold));
    assign delta_x  = fpd_pkg::DIFF_W'(i_cfg.stable_delta);

    always_comb begin
        o_item.mean    = mean;
        o_item.newest  = tap_a;
        o_item.launch  = mean_x > launch_x;
        o_item.landed  = mean_x < landed_x;
        o_item.stable  = (fpd_pkg::abs_diff(tap_a, tap_b) < delta_x)
                      && (fpd_pkg::abs_diff(tap_b, tap_c) < delta_x)
                      && (fpd_pkg::abs_diff(tap_c, tap_d) < delta_x);
        o_item.falling = (tap_a < tap_b) && (tap_b < tap_c);
    end

    // Window shift line and running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fpd_pkg::WINDOW_DEPTH; k++) begin
                r_win[k] <= '0;
            end
            r_sum <= '0;
        end else if (o_push) begin
            r_win[0] <= i_altitude_sample;
            for (int k = 1; k < fpd_pkg::WINDOW_DEPTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_sum <= n_sum;
        end
    end

endmodule

>>> sv/fpd_queue.sv
// Short queue of classified samples between the front and the back.
module fpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fpd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fpd_pkg::t_item o_item
);

    fpd_pkg::t_item              r_mem [fpd_pkg::QUEUE_DEPTH];
    logic [fpd_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [fpd_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [fpd_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == fpd_pkg::QCNT_W'(fpd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/fpd_back.sv
// Back end: flight phase machine, peak record and the result register.
module fpd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fpd_pkg::t_cfg                        i_cfg,
    input  logic                                 i_q_valid,
    input  fpd_pkg::t_item                       i_item,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [fpd_pkg::PHASE_W-1:0]          o_flight_phase,
    output logic signed [fpd_pkg::SAMPLE_W-1:0]  o_peak_altitude,
    output logic signed [fpd_pkg::SAMPLE_W-1:0]  o_mean_altitude
);

    logic [fpd_pkg::PHASE_W-1:0]         r_phase, n_phase;
    logic signed [fpd_pkg::SAMPLE_W-1:0] r_peak, n_peak;
    logic signed [fpd_pkg::SAMPLE_W-1:0] r_mean;
    logic                                r_out_valid;
    logic signed [fpd_pkg::PROD_W-1:0]   peak_frac;
    logic signed [fpd_pkg::PROD_W-1:0]   mean_scaled;
    logic                                release_hit;

    // Take the next entry when the result register is empty or being drained.
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // Release test: mean * 256 <= peak * fraction, exact.
    assign peak_frac   = r_peak * $signed({1'b0, i_cfg.release_fraction});
    assign mean_scaled = fpd_pkg::PROD_W'($signed({i_item.mean, {fpd_pkg::FRAC_SH{1'b0}}}));
    assign release_hit = mean_scaled <= peak_frac;

    // Next phase and peak.
    always_comb begin
        n_phase = r_phase;
        n_peak  = r_peak;
        unique case (r_phase)
            fpd_pkg::PH_PAD: begin
                if (i_item.launch) n_phase = fpd_pkg::PH_ASCENT;
            end
            fpd_pkg::PH_ASCENT: begin
                if (i_item.stable) begin
                    n_phase = fpd_pkg::PH_APOGEE;
                    n_peak  = i_item.newest;
                end
            end
            fpd_pkg::PH_APOGEE: begin
                if (i_item.falling) n_phase = fpd_pkg::PH_DESCENT;
            end
            fpd_pkg::PH_DESCENT: begin
                if (release_hit) n_phase = fpd_pkg::PH_RELEASE;
            end
            fpd_pkg::PH_RELEASE: begin
                if (i_item.landed) n_phase = fpd_pkg::PH_PAD;
            end
            default: begin
                n_phase = fpd_pkg::PH_PAD;
            end
        endcase
    end

    // Phase and peak advance with each entry; they double as result fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fpd_pkg::PH_PAD;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_peak  <= n_peak;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Average travels with the result.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mean <= i_item.mean;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_flight_phase  = r_phase;
    assign o_peak_altitude = r_peak;
    assign o_mean_altitude = r_mean;

endmodule

>>> sv/flight_phase_detector_core.sv
// Top level of the flight phase detector: configuration registers and the three parts.
//
// Each request carries one altitude sample in cm and yields one result: the flight phase
// after that sample, the peak recorded on entering apogee, and the floor average of the
// last four samples (the window starts out as zeros after reset). One sample can be
// accepted in every cycle while the queue is not full; the rate is set by the phase
// register in the back end, which advances once per sample. The front end holds the
// window and running sum and classifies each sample; a two-entry queue between front and
// back lets either side stall without stopping the other. Configuration registers take
// effect for samples accepted after the write and should be written only while no
// request is in flight.
module flight_phase_detector_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Sample channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [fpd_pkg::SAMPLE_W-1:0]    i_altitude_sample,
    // Result channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [fpd_pkg::PHASE_W-1:0]            o_flight_phase,
    output logic signed [fpd_pkg::SAMPLE_W-1:0]    o_peak_altitude,
    output logic signed [fpd_pkg::SAMPLE_W-1:0]    o_mean_altitude,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [fpd_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    fpd_pkg::t_cfg  r_cfg;
    fpd_pkg::t_item front_item;
    fpd_pkg::t_item q_item;
    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_threshold <= fpd_pkg::RST_LAUNCH;
            r_cfg.stable_delta     <= fpd_pkg::RST_STABLE;
            r_cfg.landed_threshold <= fpd_pkg::RST_LANDED;
            r_cfg.release_fraction <= fpd_pkg::RST_FRACTION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fpd_pkg::CFG_LAUNCH:   r_cfg.launch_threshold <= i_cfg_data;
                fpd_pkg::CFG_STABLE:   r_cfg.stable_delta     <= i_cfg_data;
                fpd_pkg::CFG_LANDED:   r_cfg.landed_threshold <= i_cfg_data;
                fpd_pkg::CFG_FRACTION: r_cfg.release_fraction <= i_cfg_data[fpd_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = full;

    // Front end: window, sum and flags.
    fpd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_in_valid        (i_in_valid),
        .i_altitude_sample (i_altitude_sample),
        .i_full            (full),
        .o_push            (push),
        .o_item            (front_item)
    );

    // Decoupling queue.
    fpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back end: phase machine and result register.
    fpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_item          (q_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_flight_phase  (o_flight_phase),
        .o_peak_altitude (o_peak_altitude),
        .o_mean_altitude (o_mean_altitude)
    );

endmodule

>>> sv/fpd_checker.sv
// Port-level checks for the flight phase detector, bound to the top level.
module fpd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [fpd_pkg::PHASE_W-1:0]         o_flight_phase,
    input  logic signed [fpd_pkg::SAMPLE_W-1:0] o_peak_altitude,
    input  logic signed [fpd_pkg::SAMPLE_W-1:0] o_mean_altitude
);

    logic [fpd_pkg::PHASE_W-1:0]         r_last_phase;
    logic signed [fpd_pkg::SAMPLE_W-1:0] r_last_peak;
    logic                                out_take;
    logic                                phase_step_ok;

    assign out_take = o_out_valid && !i_out_stall;

    // Allowed phase moves between consecutive results: hold, advance by one, or wrap.
    assign phase_step_ok = (o_flight_phase == r_last_phase)
        || (r_last_phase == fpd_pkg::PH_PAD     && o_flight_phase == fpd_pkg::PH_ASCENT)
        || (r_last_phase == fpd_pkg::PH_ASCENT  && o_flight_phase == fpd_pkg::PH_APOGEE)
        || (r_last_phase == fpd_pkg::PH_APOGEE  && o_flight_phase == fpd_pkg::PH_DESCENT)
        || (r_last_phase == fpd_pkg::PH_DESCENT && o_flight_phase == fpd_pkg::PH_RELEASE)
        || (r_last_phase == fpd_pkg::PH_RELEASE && o_flight_phase == fpd_pkg::PH_PAD);

    // Last delivered phase and peak.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= fpd_pkg::PH_PAD;
            r_last_peak  <= '0;
        end else if (out_take) begin
            r_last_phase <= o_flight_phase;
            r_last_peak  <= o_peak_altitude;
        end
    end

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_flight_phase)
            && $stable(o_peak_altitude) && $stable(o_mean_altitude))
        else $error("stalled result changed");

    // The phase only moves one step along the flight sequence per result.
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take |-> phase_step_ok)
        else $error("illegal phase transition");

    // The peak changes only on the result that enters apogee.
    a_peak_on_apogee: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (o_peak_altitude != r_last_peak)
            |-> (o_flight_phase == fpd_pkg::PH_APOGEE && r_last_phase == fpd_pkg::PH_ASCENT))
        else $error("peak changed outside apogee entry");

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind flight_phase_detector_core fpd_checker u_fpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_flight_phase  (o_flight_phase),
    .o_peak_altitude (o_peak_altitude),
    .o_mean_altitude (o_mean_altitude)
);
